### design/e2q_pkg.sv
`default_nettype none
package e2q_pkg;
  localparam int CORDIC_ITERATIONS = 14;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_ITER = (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS
                                                                : ATAN_ENTRIES;
  localparam int AW = 16;
  localparam int QW = 16;
  // CORDIC datapath width: Q30 angles up to about +-pi and gains up to ~1.65
  localparam int CW = 34;
  localparam int SCW = 17;
  localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [QW-1:0] ONE_Q14     = 16'sd16384;

  typedef logic signed [AW-1:0] angle_t;
  typedef logic signed [QW-1:0] quat_t;
  typedef logic signed [SCW-1:0] sc_t;

  typedef struct packed {
    angle_t roll_angle;
    angle_t pitch_angle;
    angle_t yaw_angle;
  } in_item_t;

  typedef struct packed {
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    quat_t quat_w;
  } out_item_t;

  // atan(2^-i) in Q30, truncated
  function automatic logic signed [CW-1:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF; 5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF; 5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF; 5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF; 5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF; 5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF; 5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF; 5'd23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed({2'b00, v});
  endfunction
endpackage
`default_nettype wire

### design/e2q_if.sv
`default_nettype none
interface e2q_in_if;
  import e2q_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface e2q_out_if;
  import e2q_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

### design/euler_to_quaternion_unit.sv
`default_nettype none
// Euler roll/pitch/yaw to ZYX quaternion, fully pipelined.
// Pipeline depth: CORDIC_ITERATIONS + 5 register stages.
// Throughput: one item per cycle while the output is taken or empty; the CORDIC and
// product pipes all advance together. A stall freezes the whole pipe, so the output
// register holds its item. Reset (rst_n, synchronous) clears only the stage valid bits.
module euler_to_quaternion_unit (
  input wire logic clk,
  input wire logic rst_n,
  e2q_in_if.sink   in_ch,
  e2q_out_if.source out_ch
);
  import e2q_pkg::*;

  localparam int LAT = NUM_ITER + 5;

  logic [LAT-1:0] vld_r, vld_nxt;
  logic en;
  sc_t sr, cr, sp, cp, sy, cy;

  // pipe moves unless the output holds an untaken item
  assign en = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    vld_nxt = vld_r;
    if (en) vld_nxt = {vld_r[LAT-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= vld_nxt;
  end

  e2q_cordic u_roll (.clk, .en, .angle(in_ch.data.roll_angle),
                     .sin_q15(sr), .cos_q15(cr));
  e2q_cordic u_pitch (.clk, .en, .angle(in_ch.data.pitch_angle),
                      .sin_q15(sp), .cos_q15(cp));
  e2q_cordic u_yaw (.clk, .en, .angle(in_ch.data.yaw_angle),
                    .sin_q15(sy), .cos_q15(cy));

  e2q_combine u_comb (.clk, .en, .sr, .cr, .sp, .cp, .sy, .cy, .q(out_ch.data));

  assign out_ch.valid = vld_r[LAT-1];
endmodule
`default_nettype wire

### design/e2q_cordic.sv
`default_nettype none
// Pipelined CORDIC rotation: one register stage per iteration plus
// range fold in and rounding out. Advances only when en is high.
module e2q_cordic (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire e2q_pkg::angle_t angle,
  output e2q_pkg::sc_t         sin_q15,
  output e2q_pkg::sc_t         cos_q15
);
  import e2q_pkg::*;

  logic signed [CW-1:0] x_r [NUM_ITER+1];
  logic signed [CW-1:0] y_r [NUM_ITER+1];
  logic signed [CW-1:0] z_r [NUM_ITER+1];
  logic                 neg_r [NUM_ITER+1];
  logic signed [CW-1:0] z_in;
  sc_t sin_r, cos_r;

  // range fold of the half angle
  always_comb begin
    z_in = CW'(angle) <<< 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= GAIN_Q30;
      y_r[0] <= '0;
      if (z_in > HALF_PI_Q30) begin
        z_r[0] <= z_in - PI_Q30;
        neg_r[0] <= 1'b1;
      end else if (z_in < -HALF_PI_Q30) begin
        z_r[0] <= z_in + PI_Q30;
        neg_r[0] <= 1'b1;
      end else begin
        z_r[0] <= z_in;
        neg_r[0] <= 1'b0;
      end
    end
  end

  // micro-rotations
  for (genvar i = 0; i < NUM_ITER; i++) begin : g_it
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (!z_r[i][CW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_q30(5'(i));
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_q30(5'(i));
        end
      end
    end
  end

  // round Q30 to Q15 and apply fold sign
  logic signed [CW-1:0] xr, yr;
  always_comb begin
    xr = (x_r[NUM_ITER] + CW'(16384)) >>> 15;
    yr = (y_r[NUM_ITER] + CW'(16384)) >>> 15;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= neg_r[NUM_ITER] ? -SCW'(xr) : SCW'(xr);
      sin_r <= neg_r[NUM_ITER] ? -SCW'(yr) : SCW'(yr);
    end
  end

  assign sin_q15 = sin_r;
  assign cos_q15 = cos_r;
endmodule
`default_nettype wire

### design/e2q_combine.sv
`default_nettype none
// Quaternion assembly: pair products, triple products, sums, round/saturate.
// Three register stages, advancing with en.
module e2q_combine (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire e2q_pkg::sc_t sr, cr, sp, cp, sy, cy,
  output e2q_pkg::out_item_t q
);
  import e2q_pkg::*;

  localparam int PW = 2 * SCW;
  localparam int TW = 3 * SCW;
  localparam int SW = TW + 1;

  logic signed [PW-1:0] cycp_r, sysp_r, sycp_r, cysp_r;
  sc_t sr1_r, cr1_r;
  logic signed [TW-1:0] t_r [8];
  out_item_t q_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cycp_r <= cy * cp;
      sysp_r <= sy * sp;
      sycp_r <= sy * cp;
      cysp_r <= cy * sp;
      sr1_r <= sr;
      cr1_r <= cr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r[0] <= cycp_r * sr1_r;
      t_r[1] <= sysp_r * cr1_r;
      t_r[2] <= sycp_r * sr1_r;
      t_r[3] <= cysp_r * cr1_r;
      t_r[4] <= sycp_r * cr1_r;
      t_r[5] <= cysp_r * sr1_r;
      t_r[6] <= cycp_r * cr1_r;
      t_r[7] <= sysp_r * sr1_r;
    end
  end

  function automatic quat_t to_q14(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] r;
    r = (v + SW'(64'sd1 <<< 30)) >>> 31;
    if (r > SW'(ONE_Q14)) return ONE_Q14;
    if (r < -SW'(ONE_Q14)) return -ONE_Q14;
    return QW'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      q_r.quat_x <= to_q14(SW'(t_r[0]) - SW'(t_r[1]));
      q_r.quat_y <= to_q14(SW'(t_r[2]) + SW'(t_r[3]));
      q_r.quat_z <= to_q14(SW'(t_r[4]) - SW'(t_r[5]));
      q_r.quat_w <= to_q14(SW'(t_r[6]) + SW'(t_r[7]));
    end
  end

  assign q = q_r;
endmodule
`default_nettype wire
